### hw/rtl/skf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_pkg - shared constants of the scalar Kalman filter
// Widths, register indexes, rounding constants and reset values.
// ----------------------------------------------------------------------------
package skf_pkg;

  // fraction bits of variances and gain, and bits taken from each sample
  localparam int FRACTION_BITS = 24;
  localparam int SAMPLE_BITS   = 16;

  localparam int WORD_W      = 32;
  localparam int SAMPLE_W    = 16;
  localparam int GAIN_OUT_W  = 25;
  localparam int CFG_INDEX_W = 2;

  // K <= 1.0, so one more bit than the fraction
  localparam int K_W     = FRACTION_BITS + 1;
  localparam int DEN_W   = WORD_W + 1;
  localparam int MAG_W   = WORD_W + 1;
  localparam int PROD_W  = MAG_W + K_W;
  localparam int ROUND_W = PROD_W + 1;
  localparam int CNT_W   = $clog2(FRACTION_BITS + 1);

  localparam logic [CFG_INDEX_W-1:0] REG_PROCESS_NOISE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MEASURE_NOISE  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_START_ESTIMATE = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_START_VARIANCE = 2'd3;

  localparam logic [K_W-1:0]     ONE_K = K_W'(1) << FRACTION_BITS;
  localparam logic [ROUND_W-1:0] HALF  = ROUND_W'(1) << (FRACTION_BITS - 1);

  localparam logic [WORD_W-1:0] PROCESS_NOISE_RESET = 32'd17;
  localparam logic [WORD_W-1:0] MEASURE_NOISE_RESET = 32'd15099;
  localparam logic [WORD_W-1:0] VARIANCE_RESET      = 32'd16777216;

endpackage

### hw/rtl/skf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_if - stream channels of the scalar Kalman filter
// Sample channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface skf_sample_if;
  logic                          valid;
  logic                          ready;
  logic [skf_pkg::SAMPLE_W-1:0]  sample;
  logic                          restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface skf_result_if;
  logic                           valid;
  logic                           ready;
  logic [skf_pkg::WORD_W-1:0]     estimate;
  logic [skf_pkg::WORD_W-1:0]     variance;
  logic [skf_pkg::GAIN_OUT_W-1:0] gain;

  modport source (output valid, output estimate, output variance, output gain,
                  input ready);
  modport sink   (input valid, input estimate, input variance, input gain,
                  output ready);
endinterface

### hw/rtl/skf_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_divider - iterative restoring divider for the gain
// Quotient of num * 2^FRACTION_BITS / den, one bit per cycle, num <= den.
// ----------------------------------------------------------------------------
module skf_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [skf_pkg::WORD_W-1:0]      num,
  input  logic [skf_pkg::DEN_W-1:0]       den,
  output logic                            done,
  output logic [skf_pkg::K_W-1:0]         quotient
);

  logic                           busy;
  logic [skf_pkg::CNT_W-1:0]      cnt;
  logic [skf_pkg::DEN_W-1:0]      rem;
  logic [skf_pkg::DEN_W-1:0]      dvs;
  logic [skf_pkg::DEN_W:0]        trial;
  logic                           ge;

  // first step tests the integer bit without a shift
  assign trial = (cnt == '0) ? {1'b0, rem} : {rem, 1'b0};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= skf_pkg::DEN_W'(num);
        dvs      <= den;
        quotient <= '0;
        cnt      <= '0;
        busy     <= 1'b1;
      end else if (busy) begin
        rem      <= ge ? skf_pkg::DEN_W'(trial - {1'b0, dvs})
                       : skf_pkg::DEN_W'(trial);
        quotient <= {quotient[skf_pkg::K_W-2:0], ge};
        cnt      <= cnt + skf_pkg::CNT_W'(1);
        if (cnt == skf_pkg::CNT_W'(skf_pkg::FRACTION_BITS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### hw/rtl/skf_multiplier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_multiplier - shared registered multiplier
// Magnitude times gain factor, product held until the next enable.
// ----------------------------------------------------------------------------
module skf_multiplier (
  input  logic                         clk,
  input  logic                         en,
  input  logic [skf_pkg::MAG_W-1:0]    a,
  input  logic [skf_pkg::K_W-1:0]      b,
  output logic [skf_pkg::PROD_W-1:0]   p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= skf_pkg::PROD_W'(a) * skf_pkg::PROD_W'(b);
    end
  end

endmodule

### hw/rtl/scalar_kalman_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_kalman_filter_unit - one-variable Kalman filter, fixed point
// Predict, gain by serial divide, estimate and variance by shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   samples : sink channel, one word per measurement (sample, restart).
//             restart = 1 loads start_estimate / start_variance first.
//   results : source channel, one word per sample (estimate Q16.16,
//             variance and gain with FRACTION_BITS fraction bits).
//   cfg_*   : write port, cfg_index selects process_noise, measure_noise,
//             start_estimate or start_variance; write only while idle.
// Timing:
//   a sample goes from acceptance through predict, divide and the two
//   multiplier passes to a result word; the restoring divider works one
//   quotient bit a cycle. One sample is in work at a time; samples.ready
//   is high only when the sequencer is idle.
// Stall:
//   the result register decouples the two sides: a new sample is taken
//   while the previous result still waits; if the result is still unread
//   when the next one is done, the sequencer holds in its final state.
// Reset:
//   clears the sequencer and result valid, loads the register reset values,
//   estimate 0 and variance 1.0.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_unit (
  input  logic                              clk,
  input  logic                              rst,
  skf_sample_if.sink                        samples,
  skf_result_if.source                      results,
  input  logic                              cfg_write,
  input  logic [skf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [skf_pkg::WORD_W-1:0]        cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PRED = 3'd1;
  localparam logic [2:0] ST_DIVS = 3'd2;
  localparam logic [2:0] ST_DIVW = 3'd3;
  localparam logic [2:0] ST_MUL1 = 3'd4;
  localparam logic [2:0] ST_MUL2 = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0] state;

  // configuration
  logic [skf_pkg::WORD_W-1:0] process_noise;
  logic [skf_pkg::WORD_W-1:0] measure_noise;
  logic [skf_pkg::WORD_W-1:0] start_estimate;
  logic [skf_pkg::WORD_W-1:0] start_variance;

  // filter state
  logic [skf_pkg::WORD_W-1:0] kept_estimate;
  logic [skf_pkg::WORD_W-1:0] kept_variance;

  // per-sample working registers
  logic [skf_pkg::SAMPLE_W-1:0] sample_reg;
  logic [skf_pkg::WORD_W-1:0]   pm_reg;
  logic [skf_pkg::DEN_W-1:0]    denom_reg;
  logic [skf_pkg::MAG_W-1:0]    mag_reg;
  logic                         neg_reg;
  logic [skf_pkg::K_W-1:0]      k_reg;
  logic [skf_pkg::WORD_W-1:0]   est_new;

  // result register
  logic                           out_valid;
  logic [skf_pkg::WORD_W-1:0]     out_estimate;
  logic [skf_pkg::WORD_W-1:0]     out_variance;
  logic [skf_pkg::GAIN_OUT_W-1:0] out_gain;

  // datapath
  logic [skf_pkg::WORD_W:0]       pm_sum;
  logic [skf_pkg::WORD_W-1:0]     pm;
  logic [skf_pkg::DEN_W-1:0]      denom;
  logic [skf_pkg::SAMPLE_BITS-1:0] smp;
  logic [skf_pkg::MAG_W-1:0]      z33;
  logic [skf_pkg::MAG_W-1:0]      diff;
  logic                           div_done;
  logic [skf_pkg::K_W-1:0]        quotient;
  logic                           mul_en;
  logic [skf_pkg::MAG_W-1:0]      mul_a;
  logic [skf_pkg::K_W-1:0]        mul_b;
  logic [skf_pkg::PROD_W-1:0]     prod;
  logic [skf_pkg::ROUND_W-1:0]    prod_rnd;
  logic [skf_pkg::MAG_W-1:0]      corr;
  logic [skf_pkg::WORD_W+1:0]     est_sum;
  logic [skf_pkg::WORD_W-1:0]     est_sat;
  logic [skf_pkg::WORD_W-1:0]     pnew;
  logic                           can_load;

  // predicted variance, saturating
  assign pm_sum = {1'b0, kept_variance} + {1'b0, process_noise};
  assign pm     = pm_sum[skf_pkg::WORD_W] ? '1 : pm_sum[skf_pkg::WORD_W-1:0];
  assign denom  = {1'b0, pm} + {1'b0, measure_noise};

  // innovation: sample as integer moved to Q16.16, minus the estimate
  assign smp  = sample_reg[skf_pkg::SAMPLE_BITS-1:0];
  assign z33  = {{(skf_pkg::MAG_W - 16 - skf_pkg::SAMPLE_BITS)
                  {smp[skf_pkg::SAMPLE_BITS-1]}}, smp, 16'b0};
  assign diff = z33 - {kept_estimate[skf_pkg::WORD_W-1], kept_estimate};

  skf_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_DIVS),
    .num      (pm_reg),
    .den      (denom_reg),
    .done     (div_done),
    .quotient (quotient)
  );

  // first pass |innovation| * K, second pass Pm * (1 - K)
  assign mul_en = (state == ST_MUL1) || (state == ST_MUL2);
  assign mul_a  = (state == ST_MUL1) ? mag_reg : {1'b0, pm_reg};
  assign mul_b  = (state == ST_MUL1) ? k_reg : skf_pkg::ONE_K - k_reg;

  skf_multiplier u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // round to nearest; sign applied after, so halves go away from zero
  assign prod_rnd = skf_pkg::ROUND_W'(prod) + skf_pkg::HALF;
  assign corr     = prod_rnd[skf_pkg::FRACTION_BITS +: skf_pkg::MAG_W];
  assign pnew     = prod_rnd[skf_pkg::FRACTION_BITS +: skf_pkg::WORD_W];

  assign est_sum = neg_reg
    ? {{2{kept_estimate[skf_pkg::WORD_W-1]}}, kept_estimate} - {1'b0, corr}
    : {{2{kept_estimate[skf_pkg::WORD_W-1]}}, kept_estimate} + {1'b0, corr};

  always_comb begin
    if (est_sum[skf_pkg::WORD_W+1 -: 3] == 3'b000 ||
        est_sum[skf_pkg::WORD_W+1 -: 3] == 3'b111) begin
      est_sat = est_sum[skf_pkg::WORD_W-1:0];
    end else if (est_sum[skf_pkg::WORD_W+1]) begin
      est_sat = {1'b1, {(skf_pkg::WORD_W-1){1'b0}}};
    end else begin
      est_sat = {1'b0, {(skf_pkg::WORD_W-1){1'b1}}};
    end
  end

  assign can_load = !out_valid || results.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise  <= skf_pkg::PROCESS_NOISE_RESET;
      measure_noise  <= skf_pkg::MEASURE_NOISE_RESET;
      start_estimate <= '0;
      start_variance <= skf_pkg::VARIANCE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        skf_pkg::REG_PROCESS_NOISE:  process_noise  <= cfg_data;
        skf_pkg::REG_MEASURE_NOISE:  measure_noise  <= cfg_data;
        skf_pkg::REG_START_ESTIMATE: start_estimate <= cfg_data;
        skf_pkg::REG_START_VARIANCE: start_variance <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      kept_estimate <= '0;
      kept_variance <= skf_pkg::VARIANCE_RESET;
    end else begin
      case (state)
        ST_IDLE: begin
          if (samples.valid) begin
            sample_reg <= samples.sample;
            if (samples.restart) begin
              kept_estimate <= start_estimate;
              kept_variance <= start_variance;
            end
            state <= ST_PRED;
          end
        end
        ST_PRED: begin
          pm_reg    <= pm;
          denom_reg <= denom;
          neg_reg   <= diff[skf_pkg::MAG_W-1];
          mag_reg   <= diff[skf_pkg::MAG_W-1] ? -diff : diff;
          state     <= ST_DIVS;
        end
        ST_DIVS: state <= ST_DIVW;
        ST_DIVW: begin
          if (div_done) begin
            // zero divisor gives zero gain
            k_reg <= (denom_reg == '0) ? '0 : quotient;
            state <= ST_MUL1;
          end
        end
        ST_MUL1: state <= ST_MUL2;
        ST_MUL2: begin
          est_new <= est_sat;
          state   <= ST_FIN;
        end
        ST_FIN: begin
          if (can_load) begin
            kept_estimate <= est_new;
            kept_variance <= pnew;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_FIN) && can_load) begin
      out_valid    <= 1'b1;
      out_estimate <= est_new;
      out_variance <= pnew;
      out_gain     <= skf_pkg::GAIN_OUT_W'(k_reg);
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign samples.ready    = (state == ST_IDLE);
  assign results.valid    = out_valid;
  assign results.estimate = out_estimate;
  assign results.variance = out_variance;
  assign results.gain     = out_gain;

  // divider finishes only while the sequencer waits for it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIVW))
    else $error("divider done outside wait state");

  // gain never exceeds one
  a_gain_le_one: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL1) |-> (k_reg <= skf_pkg::ONE_K))
    else $error("gain above one");

  // updated variance never exceeds the prediction
  a_var_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) |-> (pnew <= pm_reg))
    else $error("variance above prediction");

  // a finished result is not dropped: loading only when the register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FIN) && out_valid && !results.ready) |=> (state == ST_FIN))
    else $error("result overwritten");

endmodule
